// ----- hw/rtl/position_feedback_frame_parser_unit_assert.svh -----
`ifndef POSITION_FEEDBACK_FRAME_PARSER_UNIT_ASSERT_SVH
`define POSITION_FEEDBACK_FRAME_PARSER_UNIT_ASSERT_SVH

// property must hold on every clock while out of reset
`define PFP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfp assertion failed");

// expression must never be true while out of reset
`define PFP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pfp forbidden condition seen");

`endif

// ----- hw/rtl/pfp_pkg.sv -----
package pfp_pkg;

  localparam int CAPTURE_LIMIT_DEF = 10;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int FRAME_KEEP = 8;
  localparam int KEEP_AW    = 3;
  localparam int CHECK_SPAN = 7;

  localparam logic [7:0] POSITION_CMD = 8'h01;

  localparam logic [7:0] HEADER_RESET  = 8'h7A;
  localparam logic [7:0] MOTOR_A_RESET = 8'h01;
  localparam logic [7:0] MOTOR_B_RESET = 8'h02;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_MOTOR_A = 2'd1,
    REG_MOTOR_B = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    MATCH_NONE = 2'd0,
    MATCH_A    = 2'd1,
    MATCH_B    = 2'd2
  } match_t;

  typedef struct packed {
    logic        ok;
    logic        pos;
    logic [7:0]  sender;
    logic [31:0] position;
    match_t      matched;
  } frame_rec_t;

endpackage

// ----- hw/rtl/position_feedback_frame_parser_unit.sv -----
// Position feedback frame parser.
// Input channel (in_valid/in_ready): req_type 0 carries one received byte in
// rx_byte, req_type 1 marks line idle and ends the frame. Bytes fill an
// eight-byte buffer by running index up to CAPTURE_LIMIT; later bytes drop.
// Each idle item yields exactly one result on the output channel
// (out_valid/out_ready): header and XOR check verdict, sender id, position,
// which motor was updated and both stored motor positions. Byte items give
// no result. Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// header byte and the two motor ids; write it only while the block is idle.
// Throughput: one item per cycle while in_ready is high, bytes and idle
// events alike. An accepted idle item is written to the front-to-back
// queue and then moved to the output register, which raises out_valid.
// A stalled receiver holds the output register; the queue of QUEUE_DEPTH
// results then fills and in_ready drops, while bytes keep flowing until it
// is full. Reset clears buffer, index and both positions and restores the
// register defaults; output and queue come up empty.
module position_feedback_frame_parser_unit #(
  parameter int CAPTURE_LIMIT = pfp_pkg::CAPTURE_LIMIT_DEF,
  parameter int QUEUE_DEPTH   = pfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               frame_ok,
  output logic               is_position,
  output logic [7:0]         sender_id,
  output logic signed [31:0] frame_position,
  output logic [1:0]         matched_motor,
  output logic signed [31:0] motor_a_position,
  output logic signed [31:0] motor_b_position
);
  import pfp_pkg::*;

  frame_rec_t push_rec;
  frame_rec_t pop_rec;
  logic       push;
  logic       q_full;
  logic       pop;
  logic       pop_valid;

  pfp_front #(
    .CAPTURE_LIMIT(CAPTURE_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .rx_byte  (rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  pfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(pop_valid),
    .pop_rec  (pop_rec)
  );

  pfp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (pop_valid),
    .q_rec           (pop_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_ok        (frame_ok),
    .is_position     (is_position),
    .sender_id       (sender_id),
    .frame_position  (frame_position),
    .matched_motor   (matched_motor),
    .motor_a_position(motor_a_position),
    .motor_b_position(motor_b_position)
  );

endmodule

// ----- hw/rtl/pfp_front.sv -----
module pfp_front #(
  parameter int CAPTURE_LIMIT = pfp_pkg::CAPTURE_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               q_full,
  output logic               push,
  output pfp_pkg::frame_rec_t push_rec
);
  import pfp_pkg::*;

  localparam int IW = $clog2(CAPTURE_LIMIT + 1);

  logic [7:0]    frame_bytes [FRAME_KEEP];
  logic [IW-1:0] byte_index;
  logic [7:0]    header_byte;
  logic [7:0]    motor_a_id;
  logic [7:0]    motor_b_id;

  logic       accept;
  logic [7:0] check;
  logic       ok;
  logic       pos;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign push      = accept && (req_type == REQ_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      header_byte <= HEADER_RESET;
      motor_a_id  <= MOTOR_A_RESET;
      motor_b_id  <= MOTOR_B_RESET;
      for (int i = 0; i < FRAME_KEEP; i++) begin
        frame_bytes[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_HEADER:  header_byte <= cfg_data;
          REG_MOTOR_A: motor_a_id  <= cfg_data;
          REG_MOTOR_B: motor_b_id  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (req_type == REQ_IDLE) begin
          byte_index <= '0;
        end else if (byte_index < IW'(CAPTURE_LIMIT)) begin
          if (byte_index < IW'(FRAME_KEEP)) begin
            frame_bytes[byte_index[KEEP_AW-1:0]] <= rx_byte;
          end
          byte_index <= byte_index + 1'b1;
        end
      end
    end
  end

  always_comb begin
    check = 8'h00;
    for (int k = 0; k < CHECK_SPAN; k++) begin
      check = check ^ frame_bytes[k];
    end
  end

  assign ok  = (frame_bytes[0] == header_byte) && (frame_bytes[CHECK_SPAN] == check);
  assign pos = ok && (frame_bytes[2] == POSITION_CMD);

  always_comb begin
    push_rec.ok       = ok;
    push_rec.pos      = pos;
    push_rec.sender   = frame_bytes[1];
    push_rec.position = pos ? {frame_bytes[3], frame_bytes[4], frame_bytes[5], frame_bytes[6]}
                            : 32'h0;
    push_rec.matched  = MATCH_NONE;
    if (pos) begin
      if (frame_bytes[1] == motor_a_id) begin
        push_rec.matched = MATCH_A;
      end else if (frame_bytes[1] == motor_b_id) begin
        push_rec.matched = MATCH_B;
      end
    end
  end

endmodule

// ----- hw/rtl/pfp_queue.sv -----
module pfp_queue #(
  parameter int DEPTH = pfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfp_pkg::frame_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output pfp_pkg::frame_rec_t pop_rec
);
  import pfp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_rec_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_rec   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/pfp_back.sv -----
module pfp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  pfp_pkg::frame_rec_t q_rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                frame_ok,
  output logic                is_position,
  output logic [7:0]          sender_id,
  output logic signed [31:0]  frame_position,
  output logic [1:0]          matched_motor,
  output logic signed [31:0]  motor_a_position,
  output logic signed [31:0]  motor_b_position
);
  import pfp_pkg::*;

  logic [31:0] position_a;
  logic [31:0] position_b;
  frame_rec_t  result;

  assign pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      position_a <= 32'h0;
      position_b <= 32'h0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (q_rec.matched == MATCH_A) begin
          position_a <= q_rec.position;
        end
        if (q_rec.matched == MATCH_B) begin
          position_b <= q_rec.position;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= q_rec;
    end
  end

  assign frame_ok         = result.ok;
  assign is_position      = result.pos;
  assign sender_id        = result.sender;
  assign frame_position   = $signed(result.position);
  assign matched_motor    = result.matched;
  assign motor_a_position = $signed(position_a);
  assign motor_b_position = $signed(position_b);

endmodule

// ----- hw/rtl/pfp_checker.sv -----
`include "position_feedback_frame_parser_unit_assert.svh"

module pfp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               frame_ok,
  input logic               is_position,
  input logic signed [31:0] frame_position,
  input logic [1:0]         matched_motor,
  input logic signed [31:0] motor_a_position,
  input logic signed [31:0] motor_b_position
);
  import pfp_pkg::*;

  `PFP_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(frame_position) && $stable(matched_motor))
  `PFP_ASSERT_NEVER(a_pos_needs_ok, clk, rst, out_valid && is_position && !frame_ok)
  `PFP_ASSERT(a_nonpos_clean, clk, rst, out_valid && !is_position |-> frame_position == 32'sd0 && matched_motor == MATCH_NONE)
  `PFP_ASSERT(a_match_a_stored, clk, rst, out_valid && matched_motor == MATCH_A |-> motor_a_position == frame_position)
  `PFP_ASSERT(a_match_b_stored, clk, rst, out_valid && matched_motor == MATCH_B |-> motor_b_position == frame_position)

endmodule

bind position_feedback_frame_parser_unit pfp_checker u_pfp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .frame_ok        (frame_ok),
  .is_position     (is_position),
  .frame_position  (frame_position),
  .matched_motor   (matched_motor),
  .motor_a_position(motor_a_position),
  .motor_b_position(motor_b_position)
);
